### rtl/jvus_pkg.sv
// ----------------------------------------------------------------------------
// jvus_pkg
// Shared widths, reset limits and beat types of the joint velocity scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package jvus_pkg;

  localparam int unsigned LANES          = 6;
  localparam int unsigned JOINT_COUNT    = 6;
  localparam int unsigned VEL_W          = 16;
  localparam int unsigned LIM_W          = 15;
  localparam int unsigned MAG_W          = 16;
  localparam int unsigned Q_W            = 16;
  localparam int unsigned SCALE_W        = Q_W + 1;
  localparam int unsigned DIV_STAGES     = 4;
  localparam int unsigned BITS_PER_STAGE = Q_W / DIV_STAGES;
  localparam int unsigned CFG_IDX_W      = $clog2(LANES);
  // lane entry + divider stages + merge + multiply + output register
  localparam int unsigned DEPTH          = DIV_STAGES + 4;

  localparam logic [SCALE_W-1:0] ONE_Q16 = SCALE_W'(1) << Q_W;

  localparam logic [LANES-1:0][LIM_W-1:0] LIMIT_RESET = {
    15'd17872, 15'd10723, 15'd10723, 15'd6434, 15'd5362, 15'd5362
  };

  typedef struct packed {
    logic [SCALE_W-1:0] ratio;
    logic [MAG_W-1:0]   mag;
    logic               neg;
    logic               exceed;
  } lane_res_t;

  typedef struct packed {
    logic [SCALE_W-1:0]          scale;
    logic                        limited;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][MAG_W-1:0] mag;
  } merge_t;

  typedef struct packed {
    logic [SCALE_W-1:0]          scale;
    logic                        limited;
    logic [LANES-1:0][VEL_W-1:0] scaled;
  } out_t;

endpackage

`default_nettype wire

### rtl/jvus_in_if.sv
// ----------------------------------------------------------------------------
// jvus_in_if
// Command channel: one beat carries the six joint velocities.
// ----------------------------------------------------------------------------
`default_nettype none

interface jvus_in_if import jvus_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] velocity_0;
  logic signed [VEL_W-1:0] velocity_1;
  logic signed [VEL_W-1:0] velocity_2;
  logic signed [VEL_W-1:0] velocity_3;
  logic signed [VEL_W-1:0] velocity_4;
  logic signed [VEL_W-1:0] velocity_5;

  modport source (
    output valid, velocity_0, velocity_1, velocity_2, velocity_3, velocity_4, velocity_5,
    input  ready
  );
  modport sink (
    input  valid, velocity_0, velocity_1, velocity_2, velocity_3, velocity_4, velocity_5,
    output ready
  );
endinterface

`default_nettype wire

### rtl/jvus_out_if.sv
// ----------------------------------------------------------------------------
// jvus_out_if
// Result channel: scaled velocities, applied scale and limit flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface jvus_out_if import jvus_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] scaled_0;
  logic signed [VEL_W-1:0] scaled_1;
  logic signed [VEL_W-1:0] scaled_2;
  logic signed [VEL_W-1:0] scaled_3;
  logic signed [VEL_W-1:0] scaled_4;
  logic signed [VEL_W-1:0] scaled_5;
  logic [SCALE_W-1:0]      scale_factor;
  logic                    was_limited;

  modport source (
    output valid, scaled_0, scaled_1, scaled_2, scaled_3, scaled_4, scaled_5,
           scale_factor, was_limited,
    input  ready
  );
  modport sink (
    input  valid, scaled_0, scaled_1, scaled_2, scaled_3, scaled_4, scaled_5,
           scale_factor, was_limited,
    output ready
  );
endinterface

`default_nettype wire

### rtl/jvus_lane.sv
// ----------------------------------------------------------------------------
// jvus_lane
// One joint: magnitude, limit compare and a pipelined restoring divider
// forming limit*2^16/|v|, four quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jvus_lane import jvus_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic [DIV_STAGES:0]     en_i,
  input  wire logic signed [VEL_W-1:0] vel_i,
  input  wire logic [LIM_W-1:0]        limit_i,
  output lane_res_t                    res_o
);

  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] rem_q [DIV_STAGES];
  logic [Q_W-1:0]   quo_q [DIV_STAGES+1];
  logic [MAG_W-1:0] mag_q [DIV_STAGES+1];
  logic             neg_q [DIV_STAGES+1];
  logic             exc_q [DIV_STAGES+1];

  assign mag = vel_i[VEL_W-1] ? MAG_W'(-vel_i) : MAG_W'(vel_i);

  // remainder starts at limit; low 16 dividend bits are zero
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= MAG_W'(limit_i);
      quo_q[0] <= '0;
      mag_q[0] <= mag;
      neg_q[0] <= vel_i[VEL_W-1];
      exc_q[0] <= mag > MAG_W'(limit_i);
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [MAG_W-1:0] rem_d;
    logic [Q_W-1:0]   quo_d;

    always_comb begin
      logic [MAG_W:0] t;
      rem_d = rem_q[k-1];
      quo_d = quo_q[k-1];
      t     = '0;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        t = {rem_d, 1'b0};
        if (t >= {1'b0, mag_q[k-1]}) begin
          t     = t - {1'b0, mag_q[k-1]};
          quo_d = {quo_d[Q_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[Q_W-2:0], 1'b0};
        end
        rem_d = t[MAG_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        quo_q[k] <= quo_d;
        mag_q[k] <= mag_q[k-1];
        neg_q[k] <= neg_q[k-1];
        exc_q[k] <= exc_q[k-1];
      end
    end

    if (k < DIV_STAGES) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          rem_q[k] <= rem_d;
        end
      end
    end
  end

  assign res_o.ratio  = exc_q[DIV_STAGES] ? {1'b0, quo_q[DIV_STAGES]} : ONE_Q16;
  assign res_o.mag    = mag_q[DIV_STAGES];
  assign res_o.neg    = neg_q[DIV_STAGES];
  assign res_o.exceed = exc_q[DIV_STAGES];

endmodule

`default_nettype wire

### rtl/jvus_merge.sv
// ----------------------------------------------------------------------------
// jvus_merge
// Combines the lanes: smallest ratio becomes the common scale, any excess
// sets the limit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module jvus_merge import jvus_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire lane_res_t [LANES-1:0] lane_i,
  output merge_t                     merge_o
);

  merge_t merge_d, merge_q;

  always_comb begin
    merge_d.scale   = ONE_Q16;
    merge_d.limited = 1'b0;
    for (int j = 0; j < LANES; j++) begin
      if (lane_i[j].ratio < merge_d.scale) begin
        merge_d.scale = lane_i[j].ratio;
      end
      merge_d.limited = merge_d.limited | lane_i[j].exceed;
      merge_d.neg[j]  = lane_i[j].neg;
      merge_d.mag[j]  = lane_i[j].mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      merge_q <= merge_d;
    end
  end

  assign merge_o = merge_q;

endmodule

`default_nettype wire

### rtl/jvus_apply.sv
// ----------------------------------------------------------------------------
// jvus_apply
// Per-lane multiply by the common scale, shift by 16, restore the sign.
// Second stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jvus_apply import jvus_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic [1:0]   en_i,
  input  wire merge_t       merge_i,
  output out_t              out_o
);

  localparam int unsigned PROD_W = MAG_W + SCALE_W;

  logic [LANES-1:0][MAG_W-1:0] prod_q;
  logic [LANES-1:0]            neg_q;
  logic [SCALE_W-1:0]          scale_q;
  logic                        limited_q;
  out_t                        out_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int j = 0; j < LANES; j++) begin
        prod_q[j] <= MAG_W'((PROD_W'(merge_i.mag[j]) * PROD_W'(merge_i.scale)) >> Q_W);
      end
      neg_q     <= merge_i.neg;
      scale_q   <= merge_i.scale;
      limited_q <= merge_i.limited;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int j = 0; j < LANES; j++) begin
        out_q.scaled[j] <= neg_q[j] ? VEL_W'(MAG_W'(0) - prod_q[j]) : VEL_W'(prod_q[j]);
      end
      out_q.scale   <= scale_q;
      out_q.limited <= limited_q;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

### rtl/joint_velocity_uniform_scaler.sv
// ----------------------------------------------------------------------------
// joint_velocity_uniform_scaler
// Scales six joint velocities by one common factor so no joint exceeds its
// configured limit, keeping the direction of the motion.
//
// vel_i beats carry six signed Q5.11 velocities; res_o beats return the
// scaled velocities, the applied Q1.16 scale and a limit flag, one result
// per command, in order.
// Limits are written through cfg_we_i/cfg_idx_i/cfg_data_i only while the
// block is idle, which binds the user; the block itself does not enforce it.
// Indexes beyond the last joint are ignored. An accepted beat passes entry,
// four divider stages at four quotient bits each, merge, multiply and the
// output register before its result reaches res_o. Throughput: one beat per
// cycle while res_o is not held; the lane dividers are fully pipelined.
// Stall: each stage moves when the next one is free, so empty slots fill
// while res_o is held; vel_i.ready drops once all 8 stages hold beats.
// Reset: pipeline is emptied, limits return to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_velocity_uniform_scaler import jvus_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  jvus_in_if.sink                   vel_i,
  jvus_out_if.source                res_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LIM_W-1:0]     cfg_data_i
);

  logic [LANES-1:0][LIM_W-1:0] limit_q;
  logic [DEPTH-1:0]            vld_q, vld_d;
  logic [DEPTH-1:0]            en;
  logic signed [VEL_W-1:0]     vel [LANES];
  lane_res_t [LANES-1:0]       lane_res;
  merge_t                      merge;
  out_t                        out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else begin
      for (int j = 0; j < LANES; j++) begin
        if (cfg_we_i && cfg_idx_i == CFG_IDX_W'(j)) begin
          limit_q[j] <= cfg_data_i;
        end
      end
    end
  end

  always_comb begin
    en[DEPTH-1] = !vld_q[DEPTH-1] || res_o.ready;
    for (int k = DEPTH - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = vel_i.valid;
    end
    for (int k = 1; k < DEPTH; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign vel_i.ready = en[0];

  assign vel[0] = vel_i.velocity_0;
  assign vel[1] = vel_i.velocity_1;
  assign vel[2] = vel_i.velocity_2;
  assign vel[3] = vel_i.velocity_3;
  assign vel[4] = vel_i.velocity_4;
  assign vel[5] = vel_i.velocity_5;

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    if (j < JOINT_COUNT) begin : g_active
      jvus_lane u_lane (
        .clk_i   (clk_i),
        .en_i    (en[DIV_STAGES:0]),
        .vel_i   (vel[j]),
        .limit_i (limit_q[j]),
        .res_o   (lane_res[j])
      );
    end else begin : g_idle
      assign lane_res[j] = '{ratio: ONE_Q16, mag: '0, neg: 1'b0, exceed: 1'b0};
    end
  end

  jvus_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en[DIV_STAGES+1]),
    .lane_i  (lane_res),
    .merge_o (merge)
  );

  jvus_apply u_apply (
    .clk_i   (clk_i),
    .en_i    (en[DEPTH-1:DIV_STAGES+2]),
    .merge_i (merge),
    .out_o   (out)
  );

  assign res_o.valid        = vld_q[DEPTH-1];
  assign res_o.scaled_0     = out.scaled[0];
  assign res_o.scaled_1     = out.scaled[1];
  assign res_o.scaled_2     = out.scaled[2];
  assign res_o.scaled_3     = out.scaled[3];
  assign res_o.scaled_4     = out.scaled[4];
  assign res_o.scaled_5     = out.scaled[5];
  assign res_o.scale_factor = out.scale;
  assign res_o.was_limited  = out.limited;

endmodule

`default_nettype wire

### rtl/jvus_checker.sv
// ----------------------------------------------------------------------------
// jvus_checker
// Port-level checks of the scaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jvus_checker import jvus_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    out_valid_i,
  input wire logic                    out_ready_i,
  input wire logic signed [VEL_W-1:0] scaled_0_i,
  input wire logic signed [VEL_W-1:0] scaled_1_i,
  input wire logic signed [VEL_W-1:0] scaled_2_i,
  input wire logic signed [VEL_W-1:0] scaled_3_i,
  input wire logic signed [VEL_W-1:0] scaled_4_i,
  input wire logic signed [VEL_W-1:0] scaled_5_i,
  input wire logic [SCALE_W-1:0]      scale_factor_i,
  input wire logic                    was_limited_i
);

  // a held result beat keeps its scale, flag and joints 0 and 5
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(scale_factor_i)
      && $stable(was_limited_i) && $stable(scaled_0_i) && $stable(scaled_5_i))
    else $error("result beat changed while stalled");

  // flag set exactly when the scale is below one
  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (was_limited_i == (scale_factor_i != ONE_Q16)))
    else $error("limit flag disagrees with scale");

  // zero scale zeroes every joint
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && scale_factor_i == '0 |-> scaled_0_i == '0 && scaled_1_i == '0
      && scaled_2_i == '0 && scaled_3_i == '0 && scaled_4_i == '0 && scaled_5_i == '0)
    else $error("nonzero velocity under zero scale");

  // no result beat straight out of reset
  a_rst: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result beat at reset release");

endmodule

bind joint_velocity_uniform_scaler jvus_checker u_jvus_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .scaled_0_i     (res_o.scaled_0),
  .scaled_1_i     (res_o.scaled_1),
  .scaled_2_i     (res_o.scaled_2),
  .scaled_3_i     (res_o.scaled_3),
  .scaled_4_i     (res_o.scaled_4),
  .scaled_5_i     (res_o.scaled_5),
  .scale_factor_i (res_o.scale_factor),
  .was_limited_i  (res_o.was_limited)
);

`default_nettype wire
